[hw/rtl/dpec_pkg.sv]
// ----------------------------------------------------------------------------
// Directory page entry checker package
// Shared types, codes and constants for the directory page entry checker.
// ----------------------------------------------------------------------------
package dpec_pkg;

    localparam int unsigned TAIL_W   = 16;
    localparam int unsigned REC_W    = 16;
    localparam int unsigned NLEN_W   = 8;
    localparam int unsigned INODE_W  = 32;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned OFFS_W   = 17;
    localparam int unsigned CUR_W    = 18;
    localparam int unsigned LIMIT_W  = 17;
    localparam int unsigned LOG2_W   = 5;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] MIN_REC        = 17'd12;
    localparam logic [LOG2_W-1:0]  CHUNK_LOG2_MIN = 5'd10;
    localparam logic [LOG2_W-1:0]  CHUNK_LOG2_MAX = 5'd16;
    localparam logic [LOG2_W-1:0]  CHUNK_LOG2_RST = 5'd10;
    localparam logic [INODE_W-1:0] MAX_INODE_RST  = 32'hFFFF_FFFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INODE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEED_ENTRY   = 4'd0,
        ST_PAGE_OK      = 4'd1,
        ST_BAD_SIZE     = 4'd2,
        ST_SHORT        = 4'd3,
        ST_UNALIGNED    = 4'd4,
        ST_NAMELEN      = 4'd5,
        ST_SPAN         = 4'd6,
        ST_INODE        = 4'd7,
        ST_END_MISMATCH = 4'd8,
        ST_UNEXPECTED   = 4'd9
    } t_status;

    typedef struct packed {
        logic                 op;
        logic                 is_last_page;
        logic [TAIL_W-1:0]    tail_bytes;
        logic [REC_W-1:0]     rec_len_raw;
        logic [NLEN_W-1:0]    name_bytes;
        logic [INODE_W-1:0]   inode_number;
    } t_item;

    typedef struct packed {
        logic                 walking;
        logic [CUR_W-1:0]     cur_offset;
        logic [LIMIT_W-1:0]   page_limit;
    } t_walk_state;

    typedef struct packed {
        t_status              status;
        logic [OFFS_W-1:0]    entry_offset;
        logic                 done_res;
    } t_result;

endpackage

[hw/rtl/dpec_eval.sv]
// ----------------------------------------------------------------------------
// Directory page entry evaluator
// Combinational check of one request against the current walk state, giving
// the result and the next walk state.
// ----------------------------------------------------------------------------
module dpec_eval #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  dpec_pkg::t_item                       i_item,
    input  dpec_pkg::t_walk_state                 i_state,
    input  logic [dpec_pkg::LOG2_W-1:0]           i_chunk_log2,
    input  logic [dpec_pkg::INODE_W-1:0]          i_max_inode,
    output dpec_pkg::t_result                     o_result,
    output dpec_pkg::t_walk_state                 o_state
);

    localparam logic [dpec_pkg::LIMIT_W-1:0] PAGE_LIMIT =
        dpec_pkg::LIMIT_W'(PAGE_BYTES);
    localparam logic [dpec_pkg::LIMIT_W-1:0] PAGE_OFFS_MASK =
        dpec_pkg::LIMIT_W'(PAGE_BYTES - 1);

    logic [dpec_pkg::LOG2_W-1:0]  lg;
    logic [16:0]                  chunk_mask;
    logic [16:0]                  limit_last;
    logic [16:0]                  rec;
    logic [8:0]                   need;
    logic [18:0]                  span_end;
    logic                         span_bad;
    logic [18:0]                  sum;
    logic [17:0]                  next_off;
    logic                         cont;

    always_comb begin
        if (i_chunk_log2 < dpec_pkg::CHUNK_LOG2_MIN) begin
            lg = dpec_pkg::CHUNK_LOG2_MIN;
        end else if (i_chunk_log2 > dpec_pkg::CHUNK_LOG2_MAX) begin
            lg = dpec_pkg::CHUNK_LOG2_MAX;
        end else begin
            lg = i_chunk_log2;
        end
        chunk_mask = (17'd1 << lg) - 17'd1;

        limit_last = {1'b0, i_item.tail_bytes} & PAGE_OFFS_MASK;

        rec  = (i_item.rec_len_raw == 16'hFFFF) ? 17'h10000 : {1'b0, i_item.rec_len_raw};
        need = ({1'b0, i_item.name_bytes} + 9'd11) & 9'h1FC;

        span_end = {1'b0, i_state.cur_offset} + {2'b00, rec} - 19'd1;
        span_bad = ((span_end ^ {1'b0, i_state.cur_offset}) & ~{2'b00, chunk_mask}) != 19'd0;

        sum      = {1'b0, i_state.cur_offset} + {2'b00, rec};
        next_off = sum[17:0];
        cont     = (i_state.page_limit < dpec_pkg::MIN_REC) ||
                   (({1'b0, next_off} + 19'd12) <= {2'b00, i_state.page_limit});

        o_state               = i_state;
        o_result.status       = dpec_pkg::ST_NEED_ENTRY;
        o_result.entry_offset = '0;
        o_result.done_res     = 1'b0;

        if (i_item.op == dpec_pkg::OP_START) begin
            o_state.walking    = 1'b0;
            o_state.cur_offset = '0;
            o_result.done_res  = 1'b1;
            if (i_item.is_last_page && ((limit_last & chunk_mask) != 17'd0)) begin
                o_state.page_limit = limit_last;
                o_result.status    = dpec_pkg::ST_BAD_SIZE;
            end else if (i_item.is_last_page && (limit_last == 17'd0)) begin
                o_state.page_limit = '0;
                o_result.status    = dpec_pkg::ST_PAGE_OK;
            end else begin
                o_state.page_limit = i_item.is_last_page ? limit_last : PAGE_LIMIT;
                if (o_state.page_limit < dpec_pkg::MIN_REC) begin
                    o_result.status = dpec_pkg::ST_END_MISMATCH;
                end else begin
                    o_state.walking   = 1'b1;
                    o_result.done_res = 1'b0;
                end
            end
        end else if (!i_state.walking) begin
            o_result.status       = dpec_pkg::ST_UNEXPECTED;
            o_result.entry_offset = i_state.cur_offset[16:0];
            o_result.done_res     = 1'b1;
        end else begin
            o_result.entry_offset = i_state.cur_offset[16:0];
            o_result.done_res     = 1'b1;
            if (rec < dpec_pkg::MIN_REC) begin
                o_result.status = dpec_pkg::ST_SHORT;
            end else if (rec[1:0] != 2'b00) begin
                o_result.status = dpec_pkg::ST_UNALIGNED;
            end else if (rec < {8'd0, need}) begin
                o_result.status = dpec_pkg::ST_NAMELEN;
            end else if (span_bad) begin
                o_result.status = dpec_pkg::ST_SPAN;
            end else if (i_item.inode_number > i_max_inode) begin
                o_result.status = dpec_pkg::ST_INODE;
            end else begin
                o_result.done_res = 1'b0;
            end

            if (o_result.done_res) begin
                o_state.walking = 1'b0;
            end else begin
                o_state.cur_offset    = next_off;
                o_result.entry_offset = next_off[16:0];
                if (!cont) begin
                    o_state.walking   = 1'b0;
                    o_result.done_res = 1'b1;
                    if (next_off != {1'b0, i_state.page_limit}) begin
                        o_result.status = dpec_pkg::ST_END_MISMATCH;
                    end else begin
                        o_result.status = dpec_pkg::ST_PAGE_OK;
                    end
                end
            end
        end
    end

endmodule

[hw/rtl/directory_page_entry_checker.sv]
// ----------------------------------------------------------------------------
// Directory page entry checker
// Walks one directory page as a stream of entry headers and gives a verdict.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while its output is not stalled and
// gives one result per request. A request is captured in an input register,
// checked in one pass of short logic against the running offset and page
// limit, and written to a result register. The running walk state is updated
// as the result is written, which lets the next entry header follow in the
// very next cycle. PAGE_BYTES must be a power of two. The user must write
// configuration only while no request is in flight; the block doesn't enforce it.
module directory_page_entry_checker #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_we,
    input  logic [dpec_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dpec_pkg::CFG_W-1:0]            i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic                                  i_is_last_page,
    input  logic [dpec_pkg::TAIL_W-1:0]           i_tail_bytes,
    input  logic [dpec_pkg::REC_W-1:0]            i_rec_len_raw,
    input  logic [dpec_pkg::NLEN_W-1:0]           i_name_bytes,
    input  logic [dpec_pkg::INODE_W-1:0]          i_inode_number,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [dpec_pkg::STATUS_W-1:0]         o_status,
    output logic [dpec_pkg::OFFS_W-1:0]           o_entry_offset,
    output logic                                  o_done_res
);

    logic [dpec_pkg::LOG2_W-1:0]  r_chunk_log2;
    logic [dpec_pkg::INODE_W-1:0] r_max_inode;

    logic                         r_in_vld;
    dpec_pkg::t_item              r_item;
    logic                         r_out_vld;
    dpec_pkg::t_result            r_result;
    dpec_pkg::t_walk_state        r_state;

    dpec_pkg::t_result            n_result;
    dpec_pkg::t_walk_state        n_state;

    logic                         advance;
    logic                         in_take;

    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_log2 <= dpec_pkg::CHUNK_LOG2_RST;
            r_max_inode  <= dpec_pkg::MAX_INODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpec_pkg::CFG_CHUNK_LOG2: begin
                    r_chunk_log2 <= i_cfg_data[dpec_pkg::LOG2_W-1:0];
                end
                dpec_pkg::CFG_MAX_INODE: begin
                    r_max_inode <= i_cfg_data[dpec_pkg::INODE_W-1:0];
                end
                default: begin
                    r_max_inode <= r_max_inode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.op           <= i_op;
            r_item.is_last_page <= i_is_last_page;
            r_item.tail_bytes   <= i_tail_bytes;
            r_item.rec_len_raw  <= i_rec_len_raw;
            r_item.name_bytes   <= i_name_bytes;
            r_item.inode_number <= i_inode_number;
        end
    end

    dpec_eval #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_eval (
        .i_item       (r_item),
        .i_state      (r_state),
        .i_chunk_log2 (r_chunk_log2),
        .i_max_inode  (r_max_inode),
        .o_result     (n_result),
        .o_state      (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_result.status;
    assign o_entry_offset = r_result.entry_offset;
    assign o_done_res     = r_result.done_res;

endmodule

[dv/tb_directory_page_entry_checker.sv]
// ----------------------------------------------------------------------------
// Directory page entry checker testbench
// Feeds page start and entry header requests through the valid/stall
// handshake and predicts every verdict with an internal model of the page
// walk. Each result is checked field by field in order. The run starts with
// a directed sequence, then random pages: mostly well-formed walks, some
// broken ones and some noise. It covers several chunk sizes and inode limits
// and mixes sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_directory_page_entry_checker;

    localparam int unsigned PAGE_BYTES     = 4096;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASE_REQS     = 55;
    localparam int unsigned NUM_PHASES     = 8;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [dpec_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [dpec_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic                                 op = 1'b0;
    logic                                 is_last_page = 1'b0;
    logic [dpec_pkg::TAIL_W-1:0]          tail_bytes = '0;
    logic [dpec_pkg::REC_W-1:0]           rec_len_raw = '0;
    logic [dpec_pkg::NLEN_W-1:0]          name_bytes = '0;
    logic [dpec_pkg::INODE_W-1:0]         inode_number = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [dpec_pkg::STATUS_W-1:0]        status;
    logic [dpec_pkg::OFFS_W-1:0]          entry_offset;
    logic                                 done_res;

    logic [dpec_pkg::LOG2_W-1:0]          cfg_chunk_log2 = dpec_pkg::CHUNK_LOG2_RST;
    logic [dpec_pkg::INODE_W-1:0]         cfg_max_inode = dpec_pkg::MAX_INODE_RST;
    logic                                 walk_active = 1'b0;
    logic [dpec_pkg::CUR_W-1:0]           walk_offset = '0;
    logic [dpec_pkg::LIMIT_W-1:0]         walk_limit = '0;

    dpec_pkg::t_item                      page_requests [$];
    dpec_pkg::t_result                    expected_verdicts [$];
    dpec_pkg::t_item                      cur_req;
    int unsigned                          n_queued = 0;
    int unsigned                          n_checked = 0;
    int unsigned                          n_errors = 0;
    int unsigned                          idle_cycles = 0;
    int unsigned                          sender_idle_pct = 0;
    int unsigned                          recv_stall_pct = 0;

    logic [dpec_pkg::LOG2_W-1:0]  chunk_plan [NUM_PHASES] = '{5'd10, 5'd16, 5'd12, 5'd31,
                                                              5'd0, 5'd11, 5'd13, 5'd10};
    logic [dpec_pkg::INODE_W-1:0] inode_plan [NUM_PHASES] = '{32'hFFFF_FFFF, 32'd0,
                                                              32'h0001_0000,
                                                              32'hFFFF_FFFF, 32'd4096,
                                                              32'hFFFF_FFFE, 32'h7FFF_FFFF,
                                                              32'd5000};

    directory_page_entry_checker #(
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (op),
        .i_is_last_page(is_last_page),
        .i_tail_bytes  (tail_bytes),
        .i_rec_len_raw (rec_len_raw),
        .i_name_bytes  (name_bytes),
        .i_inode_number(inode_number),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_entry_offset(entry_offset),
        .o_done_res    (done_res)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic [18:0] clamped_chunk();
        logic [dpec_pkg::LOG2_W-1:0] lg;
        lg = cfg_chunk_log2;
        if (lg < dpec_pkg::CHUNK_LOG2_MIN) lg = dpec_pkg::CHUNK_LOG2_MIN;
        if (lg > dpec_pkg::CHUNK_LOG2_MAX) lg = dpec_pkg::CHUNK_LOG2_MAX;
        return 19'd1 << lg;
    endfunction

    function automatic dpec_pkg::t_result step_page_walk(input dpec_pkg::t_item req);
        logic [18:0]       chunk;
        logic [18:0]       lim;
        logic [18:0]       offs;
        logic [18:0]       rec;
        logic [18:0]       need;
        dpec_pkg::t_result res;
        chunk = clamped_chunk();
        res.status = dpec_pkg::ST_NEED_ENTRY;
        res.entry_offset = '0;
        res.done_res = 1'b1;
        if (req.op == dpec_pkg::OP_START) begin
            walk_active = 1'b0;
            walk_offset = '0;
            lim = 19'(PAGE_BYTES);
            if (req.is_last_page) lim = 19'(req.tail_bytes % PAGE_BYTES);
            walk_limit = lim[dpec_pkg::LIMIT_W-1:0];
            if (req.is_last_page && (lim & (chunk - 19'd1)) != 0) begin
                res.status = dpec_pkg::ST_BAD_SIZE;
            end else if (req.is_last_page && lim == 0) begin
                res.status = dpec_pkg::ST_PAGE_OK;
            end else if (lim < 19'(dpec_pkg::MIN_REC)) begin
                res.status = dpec_pkg::ST_END_MISMATCH;
            end else begin
                walk_active = 1'b1;
                res.done_res = 1'b0;
            end
            return res;
        end
        if (!walk_active) begin
            res.status = dpec_pkg::ST_UNEXPECTED;
            res.entry_offset = walk_offset[dpec_pkg::OFFS_W-1:0];
            return res;
        end
        offs = 19'(walk_offset);
        rec = (req.rec_len_raw == 16'hFFFF) ? 19'h10000 : 19'(req.rec_len_raw);
        need = (19'(req.name_bytes) + 19'd11) & ~19'd3;
        res.entry_offset = offs[dpec_pkg::OFFS_W-1:0];
        if (rec < 19'(dpec_pkg::MIN_REC)) begin
            res.status = dpec_pkg::ST_SHORT;
        end else if (rec[1:0] != 2'd0) begin
            res.status = dpec_pkg::ST_UNALIGNED;
        end else if (rec < need) begin
            res.status = dpec_pkg::ST_NAMELEN;
        end else if ((((offs + rec - 19'd1) ^ offs) & ~(chunk - 19'd1)) != 0) begin
            res.status = dpec_pkg::ST_SPAN;
        end else if (req.inode_number > cfg_max_inode) begin
            res.status = dpec_pkg::ST_INODE;
        end else begin
            offs = offs + rec;
            walk_offset = offs[dpec_pkg::CUR_W-1:0];
            res.entry_offset = offs[dpec_pkg::OFFS_W-1:0];
            if (offs <= 19'(walk_limit) - 19'(dpec_pkg::MIN_REC)) begin
                res.done_res = 1'b0;
                return res;
            end
            res.status = (offs != 19'(walk_limit)) ? dpec_pkg::ST_END_MISMATCH
                                                   : dpec_pkg::ST_PAGE_OK;
        end
        walk_active = 1'b0;
        return res;
    endfunction

    task automatic queue_request(input logic req_op, input logic last, input logic [15:0] tail,
                                 input logic [15:0] raw, input logic [7:0] nlen,
                                 input logic [31:0] ino);
        dpec_pkg::t_item req;
        req.op = req_op;
        req.is_last_page = last;
        req.tail_bytes = tail;
        req.rec_len_raw = raw;
        req.name_bytes = nlen;
        req.inode_number = ino;
        page_requests.push_back(req);
        n_queued++;
    endtask

    task automatic queue_noise();
        logic [15:0] raw;
        logic [31:0] ino;
        raw = 16'($urandom);
        ino = $urandom;
        case ($urandom_range(0, 7))
            0: raw = 16'($urandom_range(0, 13));
            1: raw = 16'hFFFF - 16'($urandom_range(0, 4));
            2: ino = cfg_max_inode + 32'($urandom_range(0, 1));
            default: ;
        endcase
        queue_request(1'($urandom), 1'($urandom), 16'($urandom), raw, 8'($urandom), ino);
    endtask

    task automatic queue_page();
        int unsigned chunk;
        int unsigned limit;
        int unsigned pos;
        int unsigned room;
        int unsigned rec;
        int unsigned pick;
        logic [15:0] tail;
        logic [15:0] raw;
        logic [7:0]  nlen;
        logic [31:0] ino;
        chunk = clamped_chunk();
        limit = PAGE_BYTES;
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 9) == 0)
                tail = 16'($urandom) | 16'd4;
            else if (chunk >= PAGE_BYTES)
                tail = 16'(PAGE_BYTES * $urandom_range(0, 15));
            else
                tail = 16'(chunk * $urandom_range(0, PAGE_BYTES / chunk - 1)
                           + PAGE_BYTES * $urandom_range(0, 15));
            queue_request(dpec_pkg::OP_START, 1'b1, tail, 16'($urandom), 8'($urandom),
                          $urandom);
            limit = tail % PAGE_BYTES;
            if (limit == 0 || (limit & (chunk - 1)) != 0) begin
                if ($urandom_range(0, 2) == 0)
                    queue_request(dpec_pkg::OP_ENTRY, 1'($urandom), 16'($urandom), 16'd12,
                                  8'd0, 32'd0);
                return;
            end
        end else begin
            queue_request(dpec_pkg::OP_START, 1'b0, 16'($urandom), 16'($urandom),
                          8'($urandom), $urandom);
        end
        pos = 0;
        while (pos < limit) begin
            room = chunk - pos % chunk;
            if (limit - pos < room) room = limit - pos;
            ino = $urandom_range(cfg_max_inode, 0);
            if ($urandom_range(0, 99) < 5) begin
                nlen = 8'($urandom_range(0, 4));
                raw = 16'd12;
                case ($urandom_range(0, 6))
                    0: raw = 16'($urandom_range(0, 11));
                    1: raw = 16'(12 + 4 * $urandom_range(0, 100) + $urandom_range(1, 3));
                    2: begin
                        raw = 16'(12 + 4 * $urandom_range(0, 58));
                        nlen = 8'($urandom_range(raw - 7, 255));
                    end
                    3: begin
                        rec = room + 4 * $urandom_range(1, 64);
                        raw = (rec >= 32'h10000) ? 16'hFFFF : 16'(rec);
                    end
                    4: begin
                        if (cfg_max_inode != 32'hFFFF_FFFF)
                            ino = $urandom_range(32'hFFFF_FFFF, cfg_max_inode + 1);
                    end
                    5: raw = 16'hFFFF;
                    default: begin
                        if (room >= 20) raw = 16'(room - 4 * $urandom_range(1, 2));
                    end
                endcase
                if ($urandom_range(0, 4) == 0) begin
                    queue_request(dpec_pkg::OP_START, 1'b0, 16'($urandom), raw, nlen, ino);
                end else begin
                    queue_request(dpec_pkg::OP_ENTRY, 1'($urandom), 16'($urandom), raw, nlen,
                                  ino);
                    if ($urandom_range(0, 3) == 0)
                        queue_request(dpec_pkg::OP_ENTRY, 1'($urandom), 16'($urandom),
                                      16'd12, 8'd0, 32'd0);
                end
                return;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                rec = 12 + 4 * $urandom_range(0, ((room - 12) / 4 < 30) ? (room - 12) / 4 : 30);
            else if (pick < 75)
                rec = room;
            else
                rec = 12 + 4 * $urandom_range(0, (room - 12) / 4);
            if (room - rec == 4 || room - rec == 8) rec = room;
            raw = (rec == 32'h10000) ? 16'hFFFF : 16'(rec);
            nlen = 8'($urandom_range(0, (rec - 8 > 255) ? 255 : rec - 8));
            if ($urandom_range(0, 9) == 0) ino = cfg_max_inode;
            queue_request(dpec_pkg::OP_ENTRY, 1'($urandom), 16'($urandom), raw, nlen, ino);
            pos += rec;
        end
    endtask

    task automatic fill_phase(input int unsigned count);
        int unsigned target;
        target = n_queued + count;
        while (n_queued < target) begin
            if ($urandom_range(0, 99) < 15)
                queue_noise();
            else
                queue_page();
        end
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dpec_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpec_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == dpec_pkg::CFG_CHUNK_LOG2)
            cfg_chunk_log2 = val[dpec_pkg::LOG2_W-1:0];
        else
            cfg_max_inode = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("%s", msg);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) expected_verdicts.push_back(step_page_walk(cur_req));
            if (!in_valid || !in_stall) begin
                if (page_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cur_req = page_requests.pop_front();
                    in_valid <= 1'b1;
                    op <= cur_req.op;
                    is_last_page <= cur_req.is_last_page;
                    tail_bytes <= cur_req.tail_bytes;
                    rec_len_raw <= cur_req.rec_len_raw;
                    name_bytes <= cur_req.name_bytes;
                    inode_number <= cur_req.inode_number;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        dpec_pkg::t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_verdicts.size() == 0) begin
                note_error($sformatf("unexpected result: status %0d offset %0d done %0b",
                                     status, entry_offset, done_res));
            end else begin
                want = expected_verdicts.pop_front();
                n_checked++;
                if (status != want.status || entry_offset != want.entry_offset ||
                    done_res != want.done_res)
                    note_error($sformatf({"verdict mismatch: expected status %0d offset %0d ",
                                          "done %0b, got status %0d offset %0d done %0b"},
                                         want.status, want.entry_offset, want.done_res,
                                         status, entry_offset, done_res));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** directory_page_entry_checker: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset configuration.
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd12, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd12, 8'd1, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd11, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd12, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'hFFFF, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd14, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd12, 8'd255, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd1028, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd1024, 8'd255, 32'hFFFF_FFFF);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b1, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b1, 16'd100, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b1, 16'd5120, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'hFFFF, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b1, 16'd5120, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd1024, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b1, 16'd1024, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd1016, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        queue_request(dpec_pkg::OP_ENTRY, 1'b0, 16'd0, 16'd16, 8'd3, 32'd7);
        queue_request(dpec_pkg::OP_START, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(dpec_pkg::CFG_CHUNK_LOG2,
                      (dpec_pkg::CFG_W'($urandom) & ~dpec_pkg::CFG_W'(32'h1F)) |
                      dpec_pkg::CFG_W'(chunk_plan[p]));
            write_reg(dpec_pkg::CFG_MAX_INODE, inode_plan[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin sender_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            fill_phase(PHASE_REQS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 expected_verdicts.size()));
        if (n_errors == 0)
            $display("** directory_page_entry_checker: PASSED **");
        else
            $display("** directory_page_entry_checker: FAILED **");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dpec_pkg.sv
hw/rtl/dpec_eval.sv
hw/rtl/directory_page_entry_checker.sv
dv/tb_directory_page_entry_checker.sv
